[src/prf_pkg.sv]
package prf_pkg;

  // operation codes carried by an input word
  typedef enum logic [2:0] {
    OP_PUSH         = 3'd0,
    OP_PULL         = 3'd1,
    OP_PEEK         = 3'd2,
    OP_RESET_PEEK   = 3'd3,
    OP_CLEAR_PEEKED = 3'd4,
    OP_CLEAR        = 3'd5,
    OP_STATUS       = 3'd6
  } prf_op_e;

  // status codes returned with each result word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } prf_status_e;

  // result flags produced by the control logic
  typedef struct packed {
    prf_status_e status;
    logic        hit;
    logic        nothing_to_peek;
    logic        is_full;
  } prf_flags_t;

  // storage access strobes from control to the byte store
  typedef struct packed {
    logic we;
    logic re;
  } prf_mem_req_t;

endpackage

[src/prf_ram.sv]
module prf_ram #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  prf_pkg::prf_mem_req_t req_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [7:0]            wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [7:0]            rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/prf_ctrl.sv]
module prf_ctrl #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [2:0]            operation_i,
  output prf_pkg::prf_mem_req_t req_o,
  output logic [AW-1:0]         waddr_o,
  output logic [AW-1:0]         raddr_o,
  output prf_pkg::prf_flags_t   flags_o,
  output logic [CW-1:0]         count_o
);

  localparam logic [AW:0]   DepthA = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] off_q, off_d;
  prf_pkg::prf_mem_req_t req;

  // position that lies off bytes past the head, wrapped at the ring size
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= DepthA) begin
      sum = sum - DepthA;
    end
    return sum[AW-1:0];
  endfunction

  // next state and result for one operation
  always_comb begin
    head_d          = head_q;
    count_d         = count_q;
    off_d           = off_q;
    req             = '0;
    flags_o.status  = prf_pkg::ST_OK;
    flags_o.hit     = 1'b0;
    waddr_o         = ring_pos(head_q, count_q[AW-1:0]);
    raddr_o         = head_q;
    unique case (prf_pkg::prf_op_e'(operation_i))
      prf_pkg::OP_PUSH: begin
        if (count_q == DepthC) begin
          flags_o.status = prf_pkg::ST_OVERFLOW;
        end else begin
          req.we  = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      prf_pkg::OP_PULL: begin
        if (count_q == '0) begin
          flags_o.status = prf_pkg::ST_UNDERFLOW;
        end else begin
          req.re      = 1'b1;
          flags_o.hit = 1'b1;
          if (count_q == CW'(1)) begin
            head_d  = '0;
            count_d = '0;
            off_d   = '0;
          end else begin
            head_d  = ring_pos(head_q, AW'(1));
            count_d = count_q - CW'(1);
            if (off_q != '0) begin
              off_d = off_q - CW'(1);
            end
          end
        end
      end
      prf_pkg::OP_PEEK: begin
        if (off_q >= count_q) begin
          flags_o.status = prf_pkg::ST_UNDERFLOW;
        end else begin
          req.re      = 1'b1;
          flags_o.hit = 1'b1;
          raddr_o     = ring_pos(head_q, off_q[AW-1:0]);
          off_d       = off_q + CW'(1);
        end
      end
      prf_pkg::OP_RESET_PEEK: begin
        off_d = '0;
      end
      prf_pkg::OP_CLEAR_PEEKED: begin
        if (off_q >= count_q) begin
          head_d  = '0;
          count_d = '0;
          off_d   = '0;
        end else begin
          head_d  = ring_pos(head_q, off_q[AW-1:0]);
          count_d = count_q - off_q;
          off_d   = '0;
        end
      end
      prf_pkg::OP_CLEAR: begin
        head_d  = '0;
        count_d = '0;
        off_d   = '0;
      end
      default: begin
        // status and the unused code only report
      end
    endcase
    flags_o.nothing_to_peek = (count_d == '0) || (off_d >= count_d);
    flags_o.is_full         = (count_d == DepthC);
  end

  assign req_o.we = req.we & accept_i;
  assign req_o.re = req.re & accept_i;
  assign count_o  = count_d;

  // ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      off_q   <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
      off_q   <= off_d;
    end
  end

endmodule

[src/peekable_ring_fifo_core.sv]
// Byte ring FIFO of DEPTH entries with a read-ahead cursor. Each input word
// carries one operation (push, pull, peek, reset peek, clear peeked, clear,
// status) and yields exactly one result word, in the cycle after acceptance, that
// gives the byte read, a status code and the fill state after the operation.
// One word is taken every cycle while the result register drains: the ring
// pointers, the byte store write and its registered read all settle in the
// accepting cycle, and the single result register holds the result word.
// A held result stalls the input. The byte store has no reset; reads only
// ever reach entries that a push has written.
module peekable_ring_fifo_core #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [2:0]    operation_i,
  input  logic [7:0]    push_byte_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    read_byte_o,
  output logic [1:0]    status_o,
  output logic          nothing_to_peek_o,
  output logic          is_full_o,
  output logic [CW-1:0] stored_count_o
);

  logic                  accept;
  prf_pkg::prf_mem_req_t mem_req;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [7:0]            rdata;
  prf_pkg::prf_flags_t   flags;
  logic [CW-1:0]         count;
  logic                  out_valid_q;
  prf_pkg::prf_flags_t   flags_q;
  logic [CW-1:0]         count_q;

  // accept when the result register is empty or being taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  prf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .req_o       (mem_req),
    .waddr_o     (waddr),
    .raddr_o     (raddr),
    .flags_o     (flags),
    .count_o     (count)
  );

  prf_ram #(.DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .waddr_i (waddr),
    .wdata_i (push_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= flags;
      count_q <= count;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_byte_o       = flags_q.hit ? rdata : 8'h00;
  assign status_o          = flags_q.status;
  assign nothing_to_peek_o = flags_q.nothing_to_peek;
  assign is_full_o         = flags_q.is_full;
  assign stored_count_o    = count_q;

  // an accepted word always shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

  // overflow is only reported when the ring is full
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == prf_pkg::ST_OVERFLOW) |-> is_full_o)
    else $error("overflow reported while not full");

  // an empty ring never has anything to peek
  a_empty_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stored_count_o == '0) |-> nothing_to_peek_o)
    else $error("empty ring reports bytes to peek");

  // a failed read returns a zero byte
  a_underflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == prf_pkg::ST_UNDERFLOW) |-> (read_byte_o == 8'h00))
    else $error("underflow returned a non-zero byte");

endmodule

[tb/sv/tb_peekable_ring_fifo_core.sv]
`timescale 1ns / 1ps

module tb_peekable_ring_fifo_core;

  localparam int DEPTH = 256;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // spare operation code, behaves as status
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // stimulus shaping
  localparam int MODE_UNIFORM = 0;
  localparam int MODE_FILL = 1;
  localparam int MODE_PUSHY = 2;
  localparam int MODE_DRAIN = 3;
  localparam int FILL_WORDS = 320;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_WORDS = 50;
  localparam int CALM_FROM = 120;
  localparam int CALM_TO = 280;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_PCT = 30;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0] op;
    logic [7:0] data;
    bit         drain_first;
  } fifo_word_t;

  typedef struct {
    logic [7:0]           read_byte;
    prf_pkg::prf_status_e status;
    logic                 nothing_to_peek;
    logic                 is_full;
    logic [CW-1:0]        stored_count;
  } fifo_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [2:0]    operation_i = prf_pkg::OP_STATUS;
  logic [7:0]    push_byte_i = 8'h00;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [7:0]    read_byte_o;
  logic [1:0]    status_o;
  logic          nothing_to_peek_o;
  logic          is_full_o;
  logic [CW-1:0] stored_count_o;

  fifo_word_t   pending_words[$];
  fifo_result_t expected_results[$];

  // predicted ring contents and pointers
  logic [7:0]    ring_bytes[DEPTH];
  logic [AW-1:0] ring_head = '0;
  logic [CW-1:0] ring_count = '0;
  logic [CW-1:0] peek_dist = '0;

  int words_sent = 0;
  int results_seen = 0;
  int total_words = 0;
  int error_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  peekable_ring_fifo_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .push_byte_i      (push_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_byte_o      (read_byte_o),
    .status_o         (status_o),
    .nothing_to_peek_o(nothing_to_peek_o),
    .is_full_o        (is_full_o),
    .stored_count_o   (stored_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // position offset bytes past the predicted head
  function automatic int ring_slot(int offset);
    int p;
    p = int'(ring_head) + offset;
    if (p >= DEPTH) p -= DEPTH;
    return p;
  endfunction

  function automatic void empty_ring();
    ring_head = '0;
    ring_count = '0;
    peek_dist = '0;
  endfunction

  // apply one operation to the predicted ring and work out its result word
  task automatic apply_fifo_op(input logic [2:0] op, input logic [7:0] data,
                               output fifo_result_t res);
    res.read_byte = 8'h00;
    res.status = prf_pkg::ST_OK;
    case (op)
      prf_pkg::OP_PUSH: begin
        if (ring_count >= DEPTH) begin
          res.status = prf_pkg::ST_OVERFLOW;
        end else begin
          ring_bytes[ring_slot(int'(ring_count))] = data;
          ring_count = ring_count + 1'b1;
        end
      end
      prf_pkg::OP_PULL: begin
        if (ring_count == 0) begin
          res.status = prf_pkg::ST_UNDERFLOW;
        end else begin
          res.read_byte = ring_bytes[ring_head];
          ring_head = AW'(ring_slot(1));
          ring_count = ring_count - 1'b1;
          // cursor stays on the same stored byte
          if (peek_dist > 0) peek_dist = peek_dist - 1'b1;
          if (ring_count == 0) empty_ring();
        end
      end
      prf_pkg::OP_PEEK: begin
        if (peek_dist >= ring_count) begin
          res.status = prf_pkg::ST_UNDERFLOW;
        end else begin
          res.read_byte = ring_bytes[ring_slot(int'(peek_dist))];
          peek_dist = peek_dist + 1'b1;
        end
      end
      prf_pkg::OP_RESET_PEEK: peek_dist = '0;
      prf_pkg::OP_CLEAR_PEEKED: begin
        // everything peeked empties the ring
        if (peek_dist >= ring_count) begin
          empty_ring();
        end else begin
          ring_head = AW'(ring_slot(int'(peek_dist)));
          ring_count = ring_count - peek_dist;
          peek_dist = '0;
        end
      end
      prf_pkg::OP_CLEAR: empty_ring();
      default: ;
    endcase
    res.nothing_to_peek = (ring_count == 0) || (peek_dist >= ring_count);
    res.is_full = (ring_count == DEPTH);
    res.stored_count = ring_count;
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got,
                                want));
  endtask

  // operation mix for each kind of random stretch
  function automatic logic [2:0] pick_op(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 90) return prf_pkg::OP_PUSH;
        if (r < 95) return prf_pkg::OP_PEEK;
        if (r < 97) return prf_pkg::OP_RESET_PEEK;
        if (r < 99) return prf_pkg::OP_STATUS;
        return OP_UNUSED;
      end
      MODE_PUSHY: if (r < 55) return prf_pkg::OP_PUSH;
      MODE_DRAIN: begin
        if (r < 35) return prf_pkg::OP_PULL;
        if (r < 65) return prf_pkg::OP_PEEK;
      end
      default: ;
    endcase
    return 3'($urandom_range(7));
  endfunction

  task automatic queue_word(logic [2:0] op, logic [7:0] data, bit drain_first);
    fifo_word_t w;
    w.op = op;
    w.data = data;
    w.drain_first = drain_first;
    pending_words.push_back(w);
  endtask

  // sender: offers queued words, predicts each one as it is taken
  always @(posedge clk_i) begin : drive_words
    fifo_result_t res;
    fifo_word_t   w;
    bit           idle;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_fifo_op(operation_i, push_byte_i, res);
        expected_results.push_back(res);
        words_sent <= words_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        idle = (words_sent >= CALM_FROM && words_sent < CALM_TO) ? 1'b0 :
               ($urandom_range(99) < IDLE_PCT);
        if (pending_words.size() != 0 && !idle &&
            !(pending_words[0].drain_first && expected_results.size() != 0)) begin
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= w.op;
          push_byte_i <= w.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result word against the oldest prediction
  always @(posedge clk_i) begin : watch_results
    fifo_result_t want;
    bit           calm;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("read_byte", 16'(read_byte_o), 16'(want.read_byte));
          check_field("status", 16'(status_o), 16'(want.status));
          check_field("nothing_to_peek", 16'(nothing_to_peek_o), 16'(want.nothing_to_peek));
          check_field("is_full", 16'(is_full_o), 16'(want.is_full));
          check_field("stored_count", 16'(stored_count_o), 16'(want.stored_count));
        end
      end
      calm = (results_seen >= CALM_FROM && results_seen < CALM_TO);
      out_stall_i <= (hold_left > 0) || (!calm && ($urandom_range(99) < IDLE_PCT));
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin : rx_hold_timer
    if (rst_ni) begin
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk_i) begin : run_limit
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_peekable_ring_fifo_core: errors");
      $finish;
    end
  end

  initial begin : stimulus
    for (int i = 0; i < DEPTH; i++) ring_bytes[i] = 8'h00;

    // empty ring corner cases
    queue_word(prf_pkg::OP_STATUS, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PULL, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PEEK, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_CLEAR_PEEKED, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_RESET_PEEK, 8'($urandom_range(255)), 1'b0);
    // byte extremes, clear peeked with nothing peeked
    queue_word(prf_pkg::OP_PUSH, 8'h00, 1'b0);
    queue_word(prf_pkg::OP_PUSH, 8'hff, 1'b0);
    queue_word(prf_pkg::OP_PUSH, 8'h5a, 1'b0);
    queue_word(prf_pkg::OP_CLEAR_PEEKED, 8'($urandom_range(255)), 1'b0);
    // pull while bytes are peeked, then peek past the end
    queue_word(prf_pkg::OP_PEEK, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PEEK, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PULL, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PEEK, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PEEK, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_RESET_PEEK, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PEEK, 8'($urandom_range(255)), 1'b0);
    // partial clear peeked, pull with cursor at head, clear peeked of all
    queue_word(prf_pkg::OP_PUSH, 8'ha5, 1'b0);
    queue_word(prf_pkg::OP_CLEAR_PEEKED, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PULL, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PEEK, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_CLEAR_PEEKED, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_PUSH, 8'h3c, 1'b0);
    queue_word(OP_UNUSED, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_CLEAR, 8'($urandom_range(255)), 1'b0);
    queue_word(prf_pkg::OP_STATUS, 8'($urandom_range(255)), 1'b0);

    // fill past full so pushes overflow, after the ring has settled
    for (int i = 0; i < FILL_WORDS; i++)
      queue_word(pick_op(MODE_FILL), 8'($urandom_range(255)), i == 0);

    // mixed stretches, the second one starting from a settled ring
    for (int s = 0; s < SEGMENTS; s++) begin
      int mode;
      mode = (s % 4 == 0) ? MODE_DRAIN : $urandom_range(MODE_PUSHY, MODE_UNIFORM);
      if (mode == MODE_FILL) mode = MODE_PUSHY;
      for (int i = 0; i < SEGMENT_WORDS; i++)
        queue_word(pick_op(mode), 8'($urandom_range(255)), s == 1 && i == 0);
    end
    total_words = pending_words.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent != total_words) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_peekable_ring_fifo_core: clean");
    end else begin
      $display("tb_peekable_ring_fifo_core: errors");
    end
    $finish;
  end

endmodule
